// File: rtl/core/tlwd_pkg.sv
`timescale 1ns / 1ps

package tlwd_pkg;

  localparam int TYPE_W     = 2;
  localparam int TIME_W     = 4;
  localparam int ELAPSED_W  = 16;
  localparam int WORK_W     = 16;
  localparam int AVG_W      = 24;
  localparam int COST_W     = 5;
  localparam int SCORE_W    = 17;
  localparam int CHOSEN_W   = 2;
  localparam int FACTOR_W   = 2;
  localparam int MASK_W     = 3;
  localparam int PEN_W      = 8;
  localparam int TMUL_W     = 4;
  localparam int AVG_SUM_W  = 27;
  localparam int THR_PROD_W = 28;
  localparam int THR_W      = 20;
  localparam int PADDR_W    = 4;
  localparam int REG_IDX_W  = 2;
  localparam int PDATA_W    = 32;

  typedef logic [WORK_W-1:0]  work_t;
  typedef logic [COST_W-1:0]  cost_t;
  typedef logic [SCORE_W-1:0] score_t;

  localparam logic [REG_IDX_W-1:0] REG_MASK    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PENALTY = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_THRESH  = 2'd2;

  localparam logic [TYPE_W-1:0] REQ_PICTURE = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_VIDEO   = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_MUSIC   = 2'd2;

  localparam logic [TIME_W-1:0] RTIME_MAX  = 4'd9;
  localparam cost_t             COST_MAX   = 5'd27;
  localparam logic [AVG_W-1:0]  AVG_RESET  = 24'd64;
  localparam logic [MASK_W-1:0] MASK_RESET = 3'd4;
  localparam logic [PEN_W-1:0]  PEN_RESET  = 8'd8;
  localparam logic [TMUL_W-1:0] TMUL_RESET = 4'd3;
  localparam work_t             WORK_MAX   = 16'hFFFF;

  // cost multiplier per server kind and request type; unknown type costs like a picture
  function automatic logic [FACTOR_W-1:0] cost_factor(input logic music_srv,
                                                      input logic [TYPE_W-1:0] rtype);
    logic [FACTOR_W-1:0] f;
    if (music_srv) begin
      case (rtype)
        REQ_MUSIC: f = 2'd1;
        REQ_VIDEO: f = 2'd3;
        default:   f = 2'd2;
      endcase
    end else begin
      case (rtype)
        REQ_MUSIC: f = 2'd2;
        default:   f = 2'd1;
      endcase
    end
    return f;
  endfunction

endpackage

// File: rtl/core/typed_least_work_dispatcher.sv
`timescale 1ns / 1ps

// Typed least-work dispatcher. Each request (media type, duration digit, seconds
// since the previous request) decays every server's pending work, updates the
// Q16.8 inter-arrival average, scores all servers in parallel and sends the
// request to the least-loaded one (lowest index on a tie), charging it the typed
// cost. One request is taken per clock unless in_stall is high; the request
// register holds it and the result register its result. The rate is set by the
// pending-work and average feedback: each request is scored against the state
// left by the one before it, so the decay, average update, threshold multiply,
// scoring and minimum search all complete between the request register and the
// result register. in_stall is raised only when the request register holds a
// request and the result register is full and stalled. Configuration sits on an
// APB port: server mask at 0x0, mismatch penalty at 0x4, threshold multiplier at 0x8.
module typed_least_work_dispatcher
  import tlwd_pkg::*;
#(
  parameter int NUM_SERVERS = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TYPE_W-1:0]     in_request_type,
  input  logic [TIME_W-1:0]     in_request_time,
  input  logic [ELAPSED_W-1:0]  in_elapsed_time,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHOSEN_W-1:0]   out_chosen_server,
  output logic [COST_W-1:0]     out_charged_cost,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  localparam int IDX_W = $clog2(NUM_SERVERS);

  // configuration
  logic [MASK_W-1:0] mask_r;
  logic [PEN_W-1:0]  pen_r;
  logic [TMUL_W-1:0] tmul_r;
  logic              cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  // request register
  logic              s1_valid_r;
  logic [TYPE_W-1:0] s1_type_r;
  logic [TIME_W-1:0] s1_time_r;
  logic [ELAPSED_W-1:0] s1_elapsed_r;

  // state
  work_t            pending_r [NUM_SERVERS];
  work_t            pending_nxt [NUM_SERVERS];
  logic [AVG_W-1:0] avg_r;
  logic [AVG_W-1:0] avg_nxt;

  // result register
  logic                out_valid_r;
  logic [CHOSEN_W-1:0] out_chosen_r;
  logic [CHOSEN_W-1:0] out_chosen_nxt;
  cost_t               out_cost_r;

  logic in_accept;
  logic advance;
  logic fire;

  logic [TIME_W-1:0]     rtime;
  logic [AVG_SUM_W-1:0]  avg_sum;
  logic [THR_PROD_W-1:0] thr_prod;
  logic [THR_W-1:0]      thres;
  logic [NUM_SERVERS-1:0] mask_ext;
  work_t                 decayed [NUM_SERVERS];
  cost_t                 cost [NUM_SERVERS];
  score_t                score [NUM_SERVERS];
  logic [IDX_W-1:0]      best_idx;
  score_t                best_score;
  cost_t                 best_cost;
  logic [WORK_W:0]       charged_sum;

  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      REG_MASK:    prdata = PDATA_W'(mask_r);
      REG_PENALTY: prdata = PDATA_W'(pen_r);
      REG_THRESH:  prdata = PDATA_W'(tmul_r);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
      pen_r  <= PEN_RESET;
      tmul_r <= TMUL_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MASK:    mask_r <= pwdata[MASK_W-1:0];
        REG_PENALTY: pen_r  <= pwdata[PEN_W-1:0];
        REG_THRESH:  tmul_r <= pwdata[TMUL_W-1:0];
        default:     ;
      endcase
    end
  end

  // handshake
  assign advance   = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_type_r    <= in_request_type;
      s1_time_r    <= in_request_time;
      s1_elapsed_r <= in_elapsed_time;
    end
  end

  assign mask_ext = NUM_SERVERS'(mask_r);

  // scoring and selection
  always_comb begin
    rtime = (s1_time_r > RTIME_MAX) ? RTIME_MAX : s1_time_r;

    // avg = (3*avg + elapsed*256) / 4
    avg_sum = {3'b000, avg_r} + {2'b00, avg_r, 1'b0} + {3'b000, s1_elapsed_r, 8'h00};
    avg_nxt = avg_sum[AVG_W+1:2];

    thr_prod = {{(THR_PROD_W-TMUL_W){1'b0}}, tmul_r} *
               {{(THR_PROD_W-AVG_W){1'b0}}, avg_nxt};
    thres    = thr_prod[THR_PROD_W-1:8];

    for (int i = 0; i < NUM_SERVERS; i++) begin
      decayed[i] = (pending_r[i] > s1_elapsed_r) ? pending_r[i] - s1_elapsed_r : '0;
      cost[i]    = {{(COST_W-FACTOR_W){1'b0}}, cost_factor(mask_ext[i], s1_type_r)} *
                   {{(COST_W-TIME_W){1'b0}}, rtime};
      score[i]   = {1'b0, decayed[i]} + SCORE_W'(cost[i]);
      if ((COST_W'(rtime) != cost[i]) && (THR_W'(cost[i]) > thres)) begin
        score[i] = score[i] + SCORE_W'(pen_r);
      end
    end

    best_idx   = '0;
    best_score = score[0];
    best_cost  = cost[0];
    for (int i = 1; i < NUM_SERVERS; i++) begin
      if (score[i] < best_score) begin
        best_idx   = IDX_W'(i);
        best_score = score[i];
        best_cost  = cost[i];
      end
    end

    charged_sum = {1'b0, decayed[best_idx]} + (WORK_W+1)'(best_cost);
    for (int i = 0; i < NUM_SERVERS; i++) begin
      pending_nxt[i] = decayed[i];
      if (IDX_W'(i) == best_idx) begin
        pending_nxt[i] = charged_sum[WORK_W] ? WORK_MAX : charged_sum[WORK_W-1:0];
      end
    end

    out_chosen_nxt = CHOSEN_W'(best_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= AVG_RESET;
      for (int i = 0; i < NUM_SERVERS; i++) begin
        pending_r[i] <= '0;
      end
    end else if (fire) begin
      avg_r <= avg_nxt;
      for (int i = 0; i < NUM_SERVERS; i++) begin
        pending_r[i] <= pending_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_chosen_r <= out_chosen_nxt;
      out_cost_r   <= best_cost;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chosen_server = out_chosen_r;
  assign out_charged_cost  = out_cost_r;

  a_cost_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cost_r <= COST_MAX))
    else $error("charged cost above maximum");

  a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result without a request in the stage");

  a_fire_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed request did not reach the result register");

  a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !in_valid && advance) |=> !s1_valid_r)
    else $error("request stage did not drain");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tlwd_pkg::*;

  localparam int                   NUM_SRV    = 3;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int                   LONG_ITEMS = 100;

  typedef struct packed {
    logic [CHOSEN_W-1:0] server;
    cost_t               cost;
  } dispatch_t;

  typedef struct packed {
    logic [TYPE_W-1:0]    rtype;
    logic [TIME_W-1:0]    rtime;
    logic [ELAPSED_W-1:0] elapsed;
    logic                 known;
    dispatch_t            result;
  } request_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [TYPE_W-1:0]    in_request_type;
  logic [TIME_W-1:0]    in_request_time;
  logic [ELAPSED_W-1:0] in_elapsed_time;
  logic                 out_valid;
  logic                 out_stall;
  logic [CHOSEN_W-1:0]  out_chosen_server;
  logic [COST_W-1:0]    out_charged_cost;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // predictor state and register copies
  work_t             load [NUM_SRV];
  logic [AVG_W-1:0]  avg_gap;
  logic [MASK_W-1:0] music_mask;
  logic [PEN_W-1:0]  penalty;
  logic [TMUL_W-1:0] tmul;

  request_t    request_q [$];
  request_t    directed_tbl [$];
  request_t    on_port;
  dispatch_t   dispatch_q [$];
  int unsigned err_cnt;
  int          burst_left;
  int          gap_left;
  int          stall_mode;
  int          stall_left;

  typed_least_work_dispatcher #(
    .NUM_SERVERS(NUM_SRV)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_request_type  (in_request_type),
    .in_request_time  (in_request_time),
    .in_elapsed_time  (in_elapsed_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chosen_server(out_chosen_server),
    .out_charged_cost (out_charged_cost),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

  // decay, average update, scoring and charge for one request
  task automatic predict_dispatch(input request_t r, output dispatch_t d);
    int unsigned t;
    int unsigned el;
    int unsigned acc;
    int unsigned thr;
    int unsigned factor;
    int unsigned cost;
    int unsigned score;
    int unsigned best_score;
    int unsigned best_cost;
    int          best;
    t = (r.rtime > RTIME_MAX) ? RTIME_MAX : r.rtime;
    el = r.elapsed;
    for (int i = 0; i < NUM_SRV; i++) begin
      load[i] = (load[i] > el) ? work_t'(load[i] - el) : '0;
    end
    acc = (3 * avg_gap + (el << 8)) >> 2;
    avg_gap = acc[AVG_W-1:0];
    thr = (tmul * avg_gap) >> 8;
    best = 0;
    best_score = 0;
    best_cost = 0;
    for (int i = 0; i < NUM_SRV; i++) begin
      if (music_mask[i]) begin
        factor = (r.rtype == REQ_MUSIC) ? 1 : (r.rtype == REQ_VIDEO) ? 3 : 2;
      end else begin
        factor = (r.rtype == REQ_MUSIC) ? 2 : 1;
      end
      cost = factor * t;
      score = load[i] + cost;
      if (t != cost && cost > thr) score = score + penalty;
      if (i == 0 || score < best_score) begin
        best_score = score;
        best_cost = cost;
        best = i;
      end
    end
    acc = load[best] + best_cost;
    load[best] = (acc > WORK_MAX) ? WORK_MAX : acc[WORK_W-1:0];
    d.server = best[CHOSEN_W-1:0];
    d.cost = best_cost[COST_W-1:0];
  endtask

  function automatic request_t row(input int ty, input int tm, input int el,
                                   input bit known, input int srv, input int cost);
    request_t r;
    r.rtype = ty[TYPE_W-1:0];
    r.rtime = tm[TIME_W-1:0];
    r.elapsed = el[ELAPSED_W-1:0];
    r.known = known;
    r.result.server = srv[CHOSEN_W-1:0];
    r.result.cost = cost[COST_W-1:0];
    return r;
  endfunction

  function automatic request_t rand_request();
    int sel;
    int el;
    int tm;
    tm = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 9);
    sel = $urandom_range(0, 19);
    if (sel < 10) el = $urandom_range(0, 3);
    else if (sel < 16) el = $urandom_range(0, 40);
    else if (sel < 19) el = $urandom_range(0, 2000);
    else el = $urandom_range(0, 65535);
    return row($urandom_range(0, 3), tm, el, 1'b0, 0, 0);
  endfunction

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MASK:    music_mask = data[MASK_W-1:0];
      REG_PENALTY: penalty = data[PEN_W-1:0];
      REG_THRESH:  tmul = data[TMUL_W-1:0];
      default:     ;
    endcase
  endtask

  task automatic cfg_read(input logic [REG_IDX_W-1:0] idx, output logic [PDATA_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    v = prdata;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    logic [PDATA_W-1:0] v;
    cfg_read(REG_MASK, v);
    if (v !== PDATA_W'(music_mask)) begin
      $display("%0t: server mask expected %h actual %h", $time, music_mask, v);
      err_cnt++;
    end
    cfg_read(REG_PENALTY, v);
    if (v !== PDATA_W'(penalty)) begin
      $display("%0t: penalty expected %h actual %h", $time, penalty, v);
      err_cnt++;
    end
    cfg_read(REG_THRESH, v);
    if (v !== PDATA_W'(tmul)) begin
      $display("%0t: threshold multiplier expected %h actual %h", $time, tmul, v);
      err_cnt++;
    end
  endtask

  task automatic configure(input int m, input int pen, input int tm);
    cfg_write(REG_MASK, ($urandom() & 32'hFFFF_FF00) | m);
    cfg_write(REG_PENALTY, ($urandom() & 32'hFFFF_FF00) | pen);
    cfg_write(REG_THRESH, ($urandom() & 32'hFFFF_FF00) | tm);
    check_regs();
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (request_q.size() != 0 || in_valid || dispatch_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // request side
  always @(posedge clk) begin
    dispatch_t d;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_dispatch(on_port, d);
        dispatch_q.push_back(on_port.known ? on_port.result : d);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          on_port = request_q.pop_front();
          in_valid        <= 1'b1;
          in_request_type <= on_port.rtype;
          in_request_time <= on_port.rtime;
          in_elapsed_time <= on_port.elapsed;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    dispatch_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (dispatch_q.size() == 0) begin
          $display("%0t: unexpected result server %0d cost %0d", $time,
                   out_chosen_server, out_charged_cost);
          err_cnt++;
        end else begin
          want = dispatch_q.pop_front();
          if (out_chosen_server !== want.server) begin
            $display("%0t: chosen server expected %0d actual %0d", $time,
                     want.server, out_chosen_server);
            err_cnt++;
          end
          if (out_charged_cost !== want.cost) begin
            $display("%0t: charged cost expected %0d actual %0d", $time,
                     want.cost, out_charged_cost);
            err_cnt++;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(8, 80);
      end else begin
        stall_left = stall_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((stall_left % 5) < 2);
      endcase
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_request_type = '0;
    in_request_time = '0;
    in_elapsed_time = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    err_cnt = 0;
    burst_left = 1;
    gap_left = 0;
    stall_mode = 0;
    stall_left = 0;
    on_port = '0;
    for (int i = 0; i < NUM_SRV; i++) load[i] = '0;
    avg_gap = AVG_RESET;
    music_mask = MASK_RESET;
    penalty = PEN_RESET;
    tmul = TMUL_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    check_regs();

    // type, time, elapsed, known, server, cost
    directed_tbl.push_back(row(REQ_MUSIC,   9,     0, 1, 2, 9));
    directed_tbl.push_back(row(REQ_VIDEO,   9, 65535, 1, 0, 9));
    directed_tbl.push_back(row(REQ_PICTURE, 0,     0, 1, 1, 0));
    directed_tbl.push_back(row(3,          15, 65535, 1, 0, 9));
    directed_tbl.push_back(row(REQ_PICTURE, 5,     0, 0, 0, 0));
    directed_tbl.push_back(row(REQ_VIDEO,   5,     0, 0, 0, 0));
    directed_tbl.push_back(row(REQ_MUSIC,   5,     0, 0, 0, 0));
    directed_tbl.push_back(row(3,           5,     0, 0, 0, 0));
    directed_tbl.push_back(row(REQ_VIDEO,   9,     0, 0, 0, 0));
    directed_tbl.push_back(row(REQ_VIDEO,   9,     0, 0, 0, 0));
    directed_tbl.push_back(row(REQ_VIDEO,   9,     0, 0, 0, 0));
    directed_tbl.push_back(row(REQ_MUSIC,   0,     1, 0, 0, 0));
    directed_tbl.push_back(row(REQ_PICTURE, 9,     1, 0, 0, 0));
    directed_tbl.push_back(row(REQ_VIDEO,  15,     2, 0, 0, 0));
    directed_tbl.push_back(row(REQ_MUSIC,  12,     0, 0, 0, 0));
    directed_tbl.push_back(row(REQ_PICTURE, 1, 65535, 0, 0, 0));
    directed_tbl.push_back(row(3,           9, 65535, 0, 0, 0));
    directed_tbl.push_back(row(REQ_VIDEO,   9,     0, 0, 0, 0));
    directed_tbl.push_back(row(REQ_MUSIC,  10, 32768, 0, 0, 0));
    directed_tbl.push_back(row(REQ_VIDEO,   1,     0, 0, 0, 0));
    foreach (directed_tbl[i]) request_q.push_back(directed_tbl[i]);
    wait_idle();

    // write outside the register map must change nothing
    cfg_write(REG_UNUSED, $urandom());
    check_regs();

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case (p)
        0:       configure(MASK_RESET, PEN_RESET, TMUL_RESET);
        1:       configure(0, 0, 0);
        2:       configure(7, 255, 15);
        3:       configure(7, 0, 15);
        default: configure($urandom_range(0, 7), $urandom_range(0, 255), $urandom_range(0, 15));
      endcase
      for (int n = 0; n < 225; n++) request_q.push_back(rand_request());
    end

    // all music servers, long video requests with no decay to build up pending work
    wait_idle();
    configure(7, $urandom_range(0, 255), $urandom_range(0, 15));
    for (int n = 0; n < LONG_ITEMS; n++) begin
      request_q.push_back(row(REQ_VIDEO, $urandom_range(9, 15), 0, 1'b0, 0, 0));
    end
    for (int n = 0; n < 30; n++) request_q.push_back(rand_request());

    wait_idle();
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
